// ----- rtl/core/chkv_pkg.sv -----
// shared types and constants of the chained hash key-value store
package chkv_pkg;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_INCR   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] lookup_key;
    logic [63:0] entry_value;
    logic [2:0]  entry_kind;
    logic [2:0]  access_rights;
    logic [3:0]  entry_options;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [2:0]  read_kind;
    logic [2:0]  read_rights;
    logic [3:0]  read_options;
    logic [31:0] created_total;
    logic [31:0] deleted_total;
    logic [31:0] lookup_total;
    logic [31:0] update_total;
    logic [31:0] collision_total;
    logic [31:0] increment_total;
    logic [8:0]  active_count;
  } out_word_t;

  typedef struct packed {
    logic       start;
    logic [7:0] divisor;
  } hash_ctl_t;

endpackage

// ----- rtl/core/chkv_hash.sv -----
// multiplicative hash and serial remainder by the bucket count
module chkv_hash (
  input  logic              clk,
  input  logic              rst_n,
  input  chkv_pkg::hash_ctl_t ctl,
  input  logic [63:0]       key,
  output logic              done,
  output logic [7:0]        bucket
);

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_MLO  = 5'b00010,
    H_MHI  = 5'b00100,
    H_ADD  = 5'b01000,
    H_DIV  = 5'b10000
  } hstate_t;

  hstate_t     state_r;
  logic [63:0] key_r;
  logic [7:0]  div_r;
  logic [63:0] plo_r;
  logic [31:0] phi_r;
  logic [63:0] h_r;
  logic [7:0]  rem_r;
  logic [3:0]  cnt_r;
  logic        done_r;
  logic [63:0] phi_full;
  logic [7:0]  rem_nxt;

  assign phi_full = key_r[63:32] * chkv_pkg::HASH_MULT;

  // four restoring remainder steps per cycle, msb first
  always_comb begin
    logic [8:0] t;
    logic [7:0] r;
    r = rem_r;
    for (int i = 0; i < 4; i++) begin
      t = {r, h_r[63-i]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r = t[7:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        H_IDLE: begin
          if (ctl.start) begin
            key_r   <= key;
            div_r   <= ctl.divisor;
            state_r <= H_MLO;
          end
        end
        H_MLO: begin
          plo_r   <= key_r[31:0] * chkv_pkg::HASH_MULT;
          state_r <= H_MHI;
        end
        H_MHI: begin
          phi_r   <= phi_full[31:0];
          state_r <= H_ADD;
        end
        H_ADD: begin
          h_r     <= plo_r + {phi_r, 32'd0};
          rem_r   <= 8'd0;
          cnt_r   <= 4'd0;
          state_r <= H_DIV;
        end
        H_DIV: begin
          rem_r <= rem_nxt;
          h_r   <= {h_r[59:0], 4'd0};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            done_r  <= 1'b1;
            state_r <= H_IDLE;
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign bucket = rem_r;

endmodule

// ----- rtl/core/chained_hash_key_value_store.sv -----
// top level of the chained hash key-value store
//
//  channel | ports                      | direction | word
//  --------+----------------------------+-----------+-------------------
//  in      | in_valid in_ready in_word  | in        | request
//  out     | out_valid out_ready out_word| out      | result
//  cfg     | cfg_we cfg_wdata           | in        | bucket count
//
// one request at a time: from accept to bucket a three-step multiply, then a
// remainder of 4 bits a cycle; then the chain head is read, each chain entry
// passed is compared, and the result is loaded on a hit or a miss; an insert
// that misses also probes slots from slot 0 when it looks for space
// after reset a clearing pass over max(ENTRIES, BUCKETS) addresses runs first
// a finished result waits in the output register while the next request
// is taken in
module chained_hash_key_value_store #(
  parameter int BUCKETS = 128,
  parameter int ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  chkv_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output chkv_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);

  localparam int SW    = $clog2(ENTRIES);
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int LW    = $clog2(ENTRIES + 1);
  localparam int CLR_N = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
  localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam logic [7:0] BC_RESET = (BUCKETS < 128) ? 8'(BUCKETS) : 8'd128;

  typedef struct packed {
    logic          valid;
    logic [SW-1:0] idx;
  } link_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic [2:0]  kind;
    logic [2:0]  rights;
    logic [3:0]  options;
    link_t       link;
  } slot_t;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_HASH  = 12'b000000000100,
    S_HEAD  = 12'b000000001000,
    S_HEADW = 12'b000000010000,
    S_STEP  = 12'b000000100000,
    S_CMP   = 12'b000001000000,
    S_HIT   = 12'b000010000000,
    S_NOHIT = 12'b000100000000,
    S_SCAN  = 12'b001000000000,
    S_SCANC = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  slot_t slot_mem [ENTRIES];
  link_t head_mem [BUCKETS];
  logic  used_mem [ENTRIES];

  state_t             state_r;
  logic [7:0]         bc_r;
  logic [7:0]         bc_nxt;
  chkv_pkg::in_word_t req_r;
  logic [BW-1:0]      bucket_r;
  link_t              head_r;
  link_t              cur_r;
  logic               has_prev_r;
  logic [SW-1:0]      prev_r;
  slot_t              prev_rec_r;
  slot_t              hit_rec_r;
  logic [LW-1:0]      len_r;
  logic [SW-1:0]      scan_r;
  logic [CW-1:0]      clr_r;
  slot_t              slot_q;
  link_t              head_q;
  logic               used_q;
  logic [1:0]         status_r;
  logic [63:0]        rv_r;
  logic [2:0]         rkind_r;
  logic [2:0]         rrights_r;
  logic [3:0]         ropts_r;
  logic [31:0]        created_r;
  logic [31:0]        deleted_r;
  logic [31:0]        lookup_r;
  logic [31:0]        update_r;
  logic [31:0]        collide_r;
  logic [31:0]        incr_r;
  logic [LW-1:0]      live_r;
  logic               out_valid_r;
  chkv_pkg::out_word_t out_r;

  chkv_pkg::hash_ctl_t hash_ctl;
  logic                hash_done;
  logic [7:0]          hash_bucket;

  logic          slot_we;
  logic [SW-1:0] slot_wa;
  slot_t         slot_wd;
  logic          head_we;
  logic [BW-1:0] head_wa;
  link_t         head_wd;
  logic          used_we;
  logic [SW-1:0] used_wa;
  logic          used_wd;
  logic          in_acc;
  logic          out_load;
  logic [63:0]   incr_val;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign incr_val = hit_rec_r.value + 64'd1;

  assign hash_ctl.start   = in_acc;
  assign hash_ctl.divisor = bc_r;

  chkv_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (hash_ctl),
    .key    (in_word.lookup_key),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  always_comb begin
    if (cfg_wdata == 8'd0) begin
      bc_nxt = 8'd1;
    end else if (32'(cfg_wdata) > BUCKETS) begin
      bc_nxt = 8'(BUCKETS);
    end else begin
      bc_nxt = cfg_wdata;
    end
  end

  // memory write ports
  always_comb begin
    slot_we = 1'b0;
    slot_wa = cur_r.idx;
    slot_wd = hit_rec_r;
    head_we = 1'b0;
    head_wa = bucket_r;
    head_wd = hit_rec_r.link;
    used_we = 1'b0;
    used_wa = cur_r.idx;
    used_wd = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        head_we         = (32'(clr_r) < BUCKETS);
        head_wa         = BW'(clr_r);
        head_wd         = '0;
        used_we         = (32'(clr_r) < ENTRIES);
        used_wa         = SW'(clr_r);
      end
      S_HIT: begin
        case (req_r.opcode)
          chkv_pkg::OP_DELETE: begin
            used_we = 1'b1;
            if (has_prev_r) begin
              slot_we            = 1'b1;
              slot_wa            = prev_r;
              slot_wd            = prev_rec_r;
              slot_wd.link       = hit_rec_r.link;
            end else begin
              head_we = 1'b1;
            end
          end
          chkv_pkg::OP_UPDATE: begin
            slot_we       = 1'b1;
            slot_wd.value = req_r.entry_value;
          end
          chkv_pkg::OP_INCR: begin
            slot_we       = 1'b1;
            slot_wd.value = incr_val;
          end
          default: ;
        endcase
      end
      S_SCANC: begin
        if (!used_q) begin
          slot_we         = 1'b1;
          slot_wa         = scan_r;
          slot_wd.key     = req_r.lookup_key;
          slot_wd.value   = req_r.entry_value;
          slot_wd.kind    = req_r.entry_kind;
          slot_wd.rights  = req_r.access_rights;
          slot_wd.options = req_r.entry_options;
          slot_wd.link    = head_r;
          head_we         = 1'b1;
          head_wd.valid   = 1'b1;
          head_wd.idx     = scan_r;
          used_we         = 1'b1;
          used_wa         = scan_r;
          used_wd         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_q <= slot_mem[cur_r.idx];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q <= head_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_q <= used_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      bc_r        <= BC_RESET;
      created_r   <= '0;
      deleted_r   <= '0;
      lookup_r    <= '0;
      update_r    <= '0;
      collide_r   <= '0;
      incr_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      bucket_r    <= '0;
      scan_r      <= '0;
    end else begin
      if (cfg_we) begin
        bc_r <= bc_nxt;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CW'(1);
          if (clr_r == CW'(CLR_N - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            req_r     <= in_word;
            status_r  <= chkv_pkg::ST_MISS;
            rv_r      <= '0;
            rkind_r   <= '0;
            rrights_r <= '0;
            ropts_r   <= '0;
            state_r   <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bucket_r <= BW'(hash_bucket);
            state_r  <= S_HEAD;
          end
        end
        S_HEAD: begin
          state_r <= S_HEADW;
        end
        S_HEADW: begin
          head_r     <= head_q;
          cur_r      <= head_q;
          has_prev_r <= 1'b0;
          len_r      <= '0;
          state_r    <= S_STEP;
        end
        S_STEP: begin
          state_r <= cur_r.valid ? S_CMP : S_NOHIT;
        end
        S_CMP: begin
          if (slot_q.key == req_r.lookup_key) begin
            hit_rec_r <= slot_q;
            state_r   <= S_HIT;
          end else begin
            prev_r     <= cur_r.idx;
            prev_rec_r <= slot_q;
            has_prev_r <= 1'b1;
            len_r      <= len_r + LW'(1);
            cur_r      <= slot_q.link;
            state_r    <= S_STEP;
          end
        end
        S_HIT: begin
          state_r  <= S_DONE;
          status_r <= chkv_pkg::ST_OK;
          case (req_r.opcode)
            chkv_pkg::OP_INSERT: status_r <= chkv_pkg::ST_DUP;
            chkv_pkg::OP_DELETE: begin
              deleted_r <= deleted_r + 32'd1;
              if (live_r != '0) begin
                live_r <= live_r - LW'(1);
              end
            end
            chkv_pkg::OP_LOOKUP: begin
              rv_r      <= hit_rec_r.value;
              rkind_r   <= hit_rec_r.kind;
              rrights_r <= hit_rec_r.rights;
              ropts_r   <= hit_rec_r.options;
              lookup_r  <= lookup_r + 32'd1;
            end
            chkv_pkg::OP_UPDATE: update_r <= update_r + 32'd1;
            chkv_pkg::OP_INCR: begin
              rv_r   <= incr_val;
              incr_r <= incr_r + 32'd1;
            end
            default: status_r <= chkv_pkg::ST_MISS;
          endcase
        end
        S_NOHIT: begin
          scan_r  <= '0;
          state_r <= (req_r.opcode == chkv_pkg::OP_INSERT) ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          state_r <= S_SCANC;
        end
        S_SCANC: begin
          if (!used_q) begin
            status_r  <= chkv_pkg::ST_OK;
            live_r    <= live_r + LW'(1);
            created_r <= created_r + 32'd1;
            collide_r <= collide_r + 32'(len_r);
            state_r   <= S_DONE;
          end else if (32'(scan_r) == ENTRIES - 1) begin
            status_r <= chkv_pkg::ST_FULL;
            state_r  <= S_DONE;
          end else begin
            scan_r  <= scan_r + SW'(1);
            state_r <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.status          <= status_r;
      out_r.read_value      <= rv_r;
      out_r.read_kind       <= rkind_r;
      out_r.read_rights     <= rrights_r;
      out_r.read_options    <= ropts_r;
      out_r.created_total   <= created_r;
      out_r.deleted_total   <= deleted_r;
      out_r.lookup_total    <= lookup_r;
      out_r.update_total    <= update_r;
      out_r.collision_total <= collide_r;
      out_r.increment_total <= incr_r;
      out_r.active_count    <= 9'(live_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
